### hw/rtl/lzw_variable_width_decoder_macros.svh
// Assertion macros used by the checker module.
`ifndef LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH
`define LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH

// Check that a condition implies a property on the same edge.
`define LZW_ASSERT_SAME(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lzw check failed");

// Check that a condition implies a property on the next edge.
`define LZW_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lzw check failed");

`endif

### hw/rtl/lzwd_pkg.sv
package lzwd_pkg;
   localparam logic [12:0] CODE_CLEAR = 13'h100;
   localparam logic [12:0] CODE_END   = 13'h101;
   localparam logic [12:0] FIRST_FREE = 13'h102;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_CODE  = 2'd1;
   localparam logic [1:0] ERR_START = 2'd2;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] out_byte;
      logic       out_valid;
      logic       finished;
      logic [1:0] error_code;
   } rsp_type;
endpackage

### hw/rtl/lzwd_ram.sv
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hw/rtl/lzwd_front.sv
// Request queue: two-entry FIFO between port and decode engine.
module lzwd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_pop,
   output lzwd_pkg::req_type q_data
);
   import lzwd_pkg::*;

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end
endmodule

### hw/rtl/lzwd_back.sv
// Decode engine: bit unpacking, dictionary walk, expansion stack.
module lzwd_back #(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  lzwd_pkg::req_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzwd_pkg::rsp_type rsp_data
);
   import lzwd_pkg::*;

   localparam int AW = MAX_CODE_BITS;
   localparam int SW = MAX_CODE_BITS + 1;
   localparam logic [SW-1:0] TABLE_SIZE = SW'(1) << MAX_CODE_BITS;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_FB_RD  = 9'b000000100,
      ST_FB_WT  = 9'b000001000,
      ST_EX_RD  = 9'b000010000,
      ST_EX_WT  = 9'b000100000,
      ST_ADD    = 9'b001000000,
      ST_POP_WT = 9'b010000000,
      ST_REPLY  = 9'b100000000
   } state_type;

   typedef enum logic [5:0] {
      PH_WAIT      = 6'b000001,
      PH_LITERAL   = 6'b000010,
      PH_RUN       = 6'b000100,
      PH_ENDED     = 6'b001000,
      PH_ERR_CODE  = 6'b010000,
      PH_ERR_START = 6'b100000
   } phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  held_ff, held_in;
   logic [4:0]  width_ff, width_in;
   logic [SW-1:0] free_ff, free_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [SW-1:0] level_ff, level_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic [AW-1:0] code_ff, code_in;
   logic [7:0]    fb_ff, fb_in;
   logic          unk_ff, unk_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          tw_en;
   logic [AW-1:0] tw_addr, t_rd_addr;
   logic [AW-1:0] tw_prefix, pf_rd;
   logic [7:0]    tw_suffix, sf_rd;
   logic          sw_en;
   logic [AW-1:0] sw_addr, s_rd_addr;
   logic [7:0]    sw_data, st_rd;

   logic [15:0]   code_mask;
   logic [15:0]   cur_code;
   logic          can_decode, active, stk_full;

   lzwd_ram #(.WIDTH(AW), .DEPTH(1 << AW)) u_prefix (
      .clock, .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(tw_prefix),
      .rd_addr(t_rd_addr), .rd_data(pf_rd));
   lzwd_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_suffix (
      .clock, .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(tw_suffix),
      .rd_addr(t_rd_addr), .rd_data(sf_rd));
   lzwd_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_stack (
      .clock, .wr_en(sw_en), .wr_addr(sw_addr), .wr_data(sw_data),
      .rd_addr(s_rd_addr), .rd_data(st_rd));

   assign active     = (phase_ff == PH_WAIT) || (phase_ff == PH_LITERAL)
                    || (phase_ff == PH_RUN);
   assign can_decode = (level_ff == '0) && active && (held_ff >= width_ff);
   assign code_mask  = 16'((17'd1 << width_ff) - 17'd1);
   assign cur_code   = buf_ff[15:0] & code_mask;
   assign stk_full   = (level_ff == TABLE_SIZE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      buf_in       = buf_ff;
      held_in      = held_ff;
      width_in     = width_ff;
      free_in      = free_ff;
      prev_in      = prev_ff;
      level_in     = level_ff;
      walk_in      = walk_ff;
      code_in      = code_ff;
      fb_in        = fb_ff;
      unk_in       = unk_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      q_pop        = 1'b0;
      tw_en        = 1'b0;
      tw_addr      = free_ff[AW-1:0];
      tw_prefix    = prev_ff;
      tw_suffix    = fb_ff;
      sw_en        = 1'b0;
      sw_addr      = level_ff[AW-1:0];
      sw_data      = sf_rd;
      t_rd_addr    = walk_ff;
      s_rd_addr    = AW'(level_ff - SW'(1));

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop           = 1'b1;
               rsp_in          = '0;
               if (q_data.action == ACT_PUSH) begin
                  if (!active) begin
                     rsp_in.accepted = 1'b1;
                     state_in        = ST_REPLY;
                  end else if (level_ff == '0 && held_ff <= 5'd16) begin
                     buf_in          = buf_ff | (24'(q_data.in_byte) << held_ff);
                     held_in         = held_ff + 5'd8;
                     rsp_in.accepted = 1'b1;
                     state_in        = ST_DECODE;
                  end else begin
                     state_in = ST_REPLY;
                  end
               end else if (level_ff != '0 && phase_ff != PH_ERR_CODE
                            && phase_ff != PH_ERR_START) begin
                  // stack top already addressed by s_rd_addr
                  level_in = level_ff - SW'(1);
                  state_in = ST_POP_WT;
               end else begin
                  state_in = ST_DECODE;
               end
            end
         end
         ST_POP_WT: begin
            rsp_in.out_byte  = st_rd;
            rsp_in.out_valid = 1'b1;
            state_in         = ST_DECODE;
         end
         ST_DECODE: begin
            if (!can_decode) begin
               state_in = ST_REPLY;
            end else begin
               buf_in  = buf_ff >> width_ff;
               held_in = held_ff - width_ff;
               priority if (phase_ff == PH_WAIT) begin
                  phase_in = (cur_code == 16'(CODE_CLEAR)) ? PH_LITERAL : PH_ERR_START;
               end else if (phase_ff == PH_LITERAL) begin
                  sw_en    = 1'b1;
                  sw_data  = cur_code[7:0];
                  level_in = level_ff + SW'(1);
                  prev_in  = AW'(cur_code[7:0]);
                  phase_in = PH_RUN;
               end else if (cur_code == 16'(CODE_CLEAR)) begin
                  width_in = 5'd9;
                  free_in  = SW'(FIRST_FREE);
                  phase_in = PH_LITERAL;
               end else if (cur_code == 16'(CODE_END)) begin
                  phase_in = PH_ENDED;
               end else if (SW'(cur_code) < free_ff) begin
                  code_in  = AW'(cur_code);
                  walk_in  = AW'(cur_code);
                  unk_in   = 1'b0;
                  state_in = ST_EX_RD;
               end else if (SW'(cur_code) == free_ff && free_ff < TABLE_SIZE) begin
                  code_in  = AW'(cur_code);
                  walk_in  = prev_ff;
                  unk_in   = 1'b1;
                  state_in = ST_FB_RD;
               end else begin
                  level_in = '0;
                  phase_in = PH_ERR_CODE;
               end
            end
         end
         ST_FB_RD: begin
            // walk prefix chain of previous code to find its first byte
            if (walk_ff <= AW'(8'hff)) begin
               fb_in    = walk_ff[7:0];
               state_in = ST_ADD;
            end else begin
               state_in = ST_FB_WT;
            end
         end
         ST_FB_WT: begin
            walk_in  = pf_rd;
            state_in = ST_FB_RD;
         end
         ST_EX_RD: begin
            if (walk_ff <= AW'(8'hff)) begin
               sw_en   = !stk_full;
               sw_data = walk_ff[7:0];
               if (!stk_full) begin
                  level_in = level_ff + SW'(1);
               end
               fb_in = walk_ff[7:0];
               if (unk_ff) begin
                  prev_in  = code_ff;
                  state_in = ST_DECODE;
               end else begin
                  state_in = ST_ADD;
               end
            end else begin
               state_in = ST_EX_WT;
            end
         end
         ST_EX_WT: begin
            sw_en   = !stk_full;
            sw_data = sf_rd;
            if (!stk_full) begin
               level_in = level_ff + SW'(1);
            end
            walk_in  = pf_rd;
            state_in = ST_EX_RD;
         end
         ST_ADD: begin
            if (free_ff < TABLE_SIZE) begin
               tw_en   = 1'b1;
               free_in = free_ff + SW'(1);
               if ((SW'(free_ff) + SW'(1)) >= (SW'(1) << width_ff)
                   && width_ff < 5'(MAX_CODE_BITS)) begin
                  width_in = width_ff + 5'd1;
               end
            end
            if (unk_ff) begin
               walk_in  = code_ff;
               state_in = ST_EX_RD;
            end else begin
               prev_in  = code_ff;
               state_in = ST_DECODE;
            end
         end
         ST_REPLY: begin
            rsp_in.finished   = (phase_ff == PH_ENDED) && (level_ff == '0);
            rsp_in.error_code = (phase_ff == PH_ERR_CODE) ? ERR_CODE :
                                (phase_ff == PH_ERR_START) ? ERR_START : ERR_NONE;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT;
         buf_ff       <= '0;
         held_ff      <= '0;
         width_ff     <= 5'd9;
         free_ff      <= SW'(FIRST_FREE);
         prev_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         buf_ff       <= buf_in;
         held_ff      <= held_in;
         width_ff     <= width_in;
         free_ff      <= free_in;
         prev_ff      <= prev_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff <= walk_in;
      code_ff <= code_in;
      fb_ff   <= fb_in;
      unk_ff  <= unk_in;
      rsp_ff  <= rsp_in;
   end
endmodule

### hw/rtl/lzw_variable_width_decoder.sv
// Sequence: a push is taken from the queue, its codes are decoded and it is answered;
// a pull that pops first reads the stack top. Each code is expanded byte by byte
// down to the root byte, then added to the dictionary; an unknown code first walks
// the previous chain. Throughput: one request at a time in the engine, the next one
// popped the cycle after a response is taken; queue is 2 deep.
// Reset: synchronous, active high; dictionary and stack RAMs are not cleared.
module lzw_variable_width_decoder #(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzwd_pkg::rsp_type rsp_data
);
   import lzwd_pkg::*;

   logic    q_valid, q_pop;
   req_type q_data;

   // front: hold incoming requests
   lzwd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_pop, .q_data);

   // back: decode, expand and reply
   lzwd_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .rsp_valid, .rsp_ready, .rsp_data);
endmodule

### hw/rtl/lzwd_checker.sv
module lzwd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input lzwd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lzwd_pkg::rsp_type rsp_data
);
   import lzwd_pkg::*;
`include "lzw_variable_width_decoder_macros.svh"

   `LZW_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data))
   `LZW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `LZW_ASSERT_SAME(a_err_range, clock, reset, rsp_valid, rsp_data.error_code != 2'd3)
   `LZW_ASSERT_SAME(a_no_both, clock, reset, rsp_valid, !(rsp_data.accepted && rsp_data.out_valid))
   `LZW_ASSERT_SAME(a_ob_zero, clock, reset, rsp_valid && !rsp_data.out_valid, rsp_data.out_byte == 8'd0)
endmodule

bind lzw_variable_width_decoder lzwd_checker u_checker (.*);
